// File: sv/elpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// elpf_pkg
// Shared types and constants of the event stream loop period finder.
// ----------------------------------------------------------------------------
package elpf_pkg;

   localparam int MAX_EVENTS_DEF = 4096;

   localparam int REG_NUM_W  = 9;
   localparam int VALUE_W    = 8;
   localparam int DELAY_W    = 32;
   localparam int EVENT_W    = REG_NUM_W + VALUE_W + DELAY_W;
   localparam int EV_FIELD_W = 13;
   localparam int REPEAT_W   = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_PERIOD_EVENTS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_PERIOD_MS     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_REPEAT        = 2'd2;

   localparam logic [EV_FIELD_W-1:0] MIN_PERIOD_EVENTS_RST = 13'd50;
   localparam logic [DELAY_W-1:0]    MIN_PERIOD_MS_RST     = 32'd2000;
   localparam logic [REPEAT_W-1:0]   MIN_REPEAT_RST        = 4'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRY,
      ST_SCAN,
      ST_CHECK,
      ST_SUM,
      ST_KPREP,
      ST_KEEP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic store;
      logic p_init;
      logic p_inc;
      logic scan_init;
      logic scan_step;
      logic run_init;
      logic keep_init;
      logic run_step;
      logic take_hit;
      logic take_miss;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic p_fits;
      logic scan_done;
      logic tail_ok;
      logic run_done;
      logic ms_ok;
   } dp_sts_type;

endpackage
`default_nettype wire

// File: sv/elpf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// elpf_dp
// Datapath: event memory, configuration registers, period/scan/sum counters
// and result registers.
// ----------------------------------------------------------------------------
module elpf_dp #(
   parameter int MAX_EVENTS = elpf_pkg::MAX_EVENTS_DEF
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_wr_en,
   input  wire  [elpf_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  wire  [elpf_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  wire  [elpf_pkg::REG_NUM_W-1:0]         req_register_number,
   input  wire  [elpf_pkg::VALUE_W-1:0]           req_write_value,
   input  wire  [elpf_pkg::DELAY_W-1:0]           req_delay_after,
   input  elpf_pkg::dp_cmd_type                   cmd,
   output elpf_pkg::dp_sts_type                   sts,
   output logic                                   rsp_found,
   output logic [elpf_pkg::EV_FIELD_W-1:0]        rsp_init_events,
   output logic [elpf_pkg::EV_FIELD_W-1:0]        rsp_loop_events,
   output logic [elpf_pkg::DELAY_W-1:0]           rsp_loop_ms,
   output logic [elpf_pkg::DELAY_W-1:0]           rsp_kept_ms,
   output logic                                   rsp_overflow
);

   localparam int CW = $clog2(MAX_EVENTS + 1);
   localparam int AW = $clog2(MAX_EVENTS);
   localparam int PW = ((CW > elpf_pkg::EV_FIELD_W) ? CW : elpf_pkg::EV_FIELD_W) + 1;
   localparam int MW = PW + elpf_pkg::REPEAT_W;
   localparam int DW = elpf_pkg::DELAY_W;
   localparam int EW = elpf_pkg::EVENT_W;
   localparam logic [CW-1:0] CAPACITY = CW'(MAX_EVENTS);

   logic [EW-1:0] mem [MAX_EVENTS];
   logic [EW-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0] addr_a, addr_b;

   logic [elpf_pkg::EV_FIELD_W-1:0] min_ev_ff, min_ev_in;
   logic [DW-1:0]                   min_ms_ff, min_ms_in;
   logic [elpf_pkg::REPEAT_W-1:0]   min_rep_ff, min_rep_in;

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [PW-1:0] p_ff, p_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] pidx_ff, pidx_in;
   logic [CW-1:0] s_ff, s_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic          found_ff, found_in;
   logic [CW-1:0] bs_ff, bs_in;
   logic [PW-1:0] bp_ff, bp_in;
   logic [DW-1:0] bms_ff, bms_in;

   logic [elpf_pkg::REPEAT_W-1:0] rep_eff;
   logic [MW-1:0]                 prod;
   logic                          hit;
   logic [PW:0]                   keep_sum;
   logic [CW-1:0]                 keep_n;

   // event memory
   always_ff @(posedge clock) begin
      if (cmd.store && (count_ff < CAPACITY)) begin
         mem[count_ff[AW-1:0]] <= {req_register_number, req_write_value, req_delay_after};
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   assign addr_a = cmd.scan_step ? AW'(i_ff - CW'(1)) : AW'(i_ff);
   assign addr_b = AW'((PW+1)'(i_ff) + (PW+1)'(p_ff) - (PW+1)'(1));

   assign rep_eff  = (min_rep_ff == '0) ? elpf_pkg::REPEAT_W'(1) : min_rep_ff;
   assign prod     = MW'(p_ff) * MW'(rep_eff);
   assign hit      = pend_ff && (rd_a_ff != rd_b_ff);
   assign keep_sum = (PW+1)'(bs_ff) + (PW+1)'(bp_ff);
   assign keep_n   = (keep_sum > (PW+1)'(count_ff)) ? count_ff : CW'(keep_sum);

   assign sts.p_fits    = prod <= MW'(count_ff);
   assign sts.scan_done = hit || ((i_ff == '0) && !pend_ff);
   assign sts.tail_ok   = MW'(count_ff - s_ff) >= prod;
   assign sts.run_done  = (cnt_ff == '0) && !pend_ff;
   assign sts.ms_ok     = acc_ff >= min_ms_ff;

   always_comb begin
      min_ev_in  = min_ev_ff;
      min_ms_in  = min_ms_ff;
      min_rep_in = min_rep_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            elpf_pkg::CSR_MIN_PERIOD_EVENTS: min_ev_in  = csr_wdata[elpf_pkg::EV_FIELD_W-1:0];
            elpf_pkg::CSR_MIN_PERIOD_MS:     min_ms_in  = csr_wdata[DW-1:0];
            elpf_pkg::CSR_MIN_REPEAT:        min_rep_in = csr_wdata[elpf_pkg::REPEAT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      p_in     = p_ff;
      i_in     = i_ff;
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      pidx_in  = pidx_ff;
      s_in     = s_ff;
      acc_in   = acc_ff;
      found_in = found_ff;
      bs_in    = bs_ff;
      bp_in    = bp_ff;
      bms_in   = bms_ff;

      if (cmd.store) begin
         if (count_ff < CAPACITY) begin
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.p_init) begin
         p_in = (min_ev_ff == '0) ? PW'(1) : PW'(min_ev_ff);
      end
      if (cmd.p_inc) begin
         p_in = p_ff + PW'(1);
      end
      if (cmd.scan_init) begin
         i_in    = count_ff - CW'(p_ff);
         pend_in = 1'b0;
         s_in    = '0;
      end
      if (cmd.scan_step) begin
         pend_in = (i_ff != '0);
         pidx_in = i_ff;
         if (i_ff != '0) begin
            i_in = i_ff - CW'(1);
         end
         if (hit) begin
            s_in = pidx_ff;
         end
      end
      if (cmd.run_init) begin
         i_in    = s_ff;
         cnt_in  = CW'(p_ff);
         acc_in  = '0;
         pend_in = 1'b0;
      end
      if (cmd.keep_init) begin
         i_in    = '0;
         cnt_in  = (keep_n == '0) ? '0 : keep_n - CW'(1);
         acc_in  = '0;
         pend_in = 1'b0;
      end
      if (cmd.run_step) begin
         pend_in = (cnt_ff != '0);
         if (cnt_ff != '0) begin
            i_in   = i_ff + CW'(1);
            cnt_in = cnt_ff - CW'(1);
         end
         if (pend_ff) begin
            acc_in = acc_ff + rd_a_ff[DW-1:0];
         end
      end
      if (cmd.take_hit) begin
         found_in = 1'b1;
         bs_in    = s_ff;
         bp_in    = p_ff;
         bms_in   = acc_ff;
      end
      if (cmd.take_miss) begin
         found_in = 1'b0;
         bs_in    = '0;
         bp_in    = PW'(count_ff);
         bms_in   = '0;
      end
      if (cmd.finish) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ev_ff  <= elpf_pkg::MIN_PERIOD_EVENTS_RST;
         min_ms_ff  <= elpf_pkg::MIN_PERIOD_MS_RST;
         min_rep_ff <= elpf_pkg::MIN_REPEAT_RST;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         min_ev_ff  <= min_ev_in;
         min_ms_ff  <= min_ms_in;
         min_rep_ff <= min_rep_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      i_ff     <= i_in;
      cnt_ff   <= cnt_in;
      pidx_ff  <= pidx_in;
      s_ff     <= s_in;
      acc_ff   <= acc_in;
      found_ff <= found_in;
      bs_ff    <= bs_in;
      bp_ff    <= bp_in;
      bms_ff   <= bms_in;
   end

   assign rsp_found       = found_ff;
   assign rsp_init_events = elpf_pkg::EV_FIELD_W'(bs_ff);
   assign rsp_loop_events = elpf_pkg::EV_FIELD_W'(bp_ff);
   assign rsp_loop_ms     = bms_ff;
   assign rsp_kept_ms     = acc_ff;
   assign rsp_overflow    = ovf_ff;

endmodule
`default_nettype wire

// File: sv/elpf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// elpf_ctrl
// Controller: sequences loading, period trials, backward scans, period sums
// and the kept-time sum.
// ----------------------------------------------------------------------------
module elpf_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  wire                   req_last,
   input  elpf_pkg::dp_sts_type  sts,
   output elpf_pkg::dp_cmd_type  cmd,
   output logic                  busy,
   output logic                  rsp_valid
);

   elpf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= elpf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         elpf_pkg::ST_IDLE: begin
            if (start && req_last) state_in = elpf_pkg::ST_TRY;
         end
         elpf_pkg::ST_TRY: begin
            state_in = sts.p_fits ? elpf_pkg::ST_SCAN : elpf_pkg::ST_KPREP;
         end
         elpf_pkg::ST_SCAN: begin
            if (sts.scan_done) state_in = elpf_pkg::ST_CHECK;
         end
         elpf_pkg::ST_CHECK: begin
            state_in = sts.tail_ok ? elpf_pkg::ST_SUM : elpf_pkg::ST_TRY;
         end
         elpf_pkg::ST_SUM: begin
            if (sts.run_done) begin
               state_in = sts.ms_ok ? elpf_pkg::ST_KPREP : elpf_pkg::ST_TRY;
            end
         end
         elpf_pkg::ST_KPREP: state_in = elpf_pkg::ST_KEEP;
         elpf_pkg::ST_KEEP: begin
            if (sts.run_done) state_in = elpf_pkg::ST_DONE;
         end
         elpf_pkg::ST_DONE: state_in = elpf_pkg::ST_IDLE;
         default: state_in = elpf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         elpf_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.store  = 1'b1;
               cmd.p_init = req_last;
            end
         end
         elpf_pkg::ST_TRY: begin
            if (sts.p_fits) cmd.scan_init = 1'b1;
            else            cmd.take_miss = 1'b1;
         end
         elpf_pkg::ST_SCAN: cmd.scan_step = 1'b1;
         elpf_pkg::ST_CHECK: begin
            if (sts.tail_ok) cmd.run_init = 1'b1;
            else             cmd.p_inc    = 1'b1;
         end
         elpf_pkg::ST_SUM: begin
            cmd.run_step = 1'b1;
            if (sts.run_done) begin
               if (sts.ms_ok) cmd.take_hit = 1'b1;
               else           cmd.p_inc    = 1'b1;
            end
         end
         elpf_pkg::ST_KPREP: cmd.keep_init = 1'b1;
         elpf_pkg::ST_KEEP:  cmd.run_step  = 1'b1;
         elpf_pkg::ST_DONE: begin
            rsp_valid  = 1'b1;
            cmd.finish = 1'b1;
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// File: sv/event_stream_loop_period_finder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// event_stream_loop_period_finder_top
// Finds the shortest repeating tail of a stored stream of timed events.
//
// Request: an event is taken on a clock edge with start high and busy low;
// one event per cycle while loading, stored in a MAX_EVENTS-deep memory.
// Events past capacity are dropped and flagged in rsp_overflow.
// The event with req_last high starts the search; busy stays high until the
// result. Each tried period P is checked in turn: a backward scan compares
// event pairs until a mismatch turns up, then, when the tail is long enough,
// the delays of one period are summed; the trials end on a hit or when a
// period no longer fits. A final pass sums the kept time, then the result is
// reported. The search is bounded by the single memory with two read ports,
// one event pair compared per cycle.
// Response: rsp_valid pulses one cycle with all rsp_ fields; the receiver
// cannot stall. The event count and overflow flag then clear.
// Configuration: csr_ writes are taken any cycle; write only while idle.
// Reset (synchronous) clears the count, the flag and the controller and
// loads the register defaults; the memory is not cleared.
// ----------------------------------------------------------------------------
module event_stream_loop_period_finder_top #(
   parameter int MAX_EVENTS = elpf_pkg::MAX_EVENTS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_wr_en,
   input  wire  [elpf_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire  [elpf_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire                                start,
   output logic                               busy,
   input  wire  [elpf_pkg::REG_NUM_W-1:0]     req_register_number,
   input  wire  [elpf_pkg::VALUE_W-1:0]       req_write_value,
   input  wire  [elpf_pkg::DELAY_W-1:0]       req_delay_after,
   input  wire                                req_last,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic [elpf_pkg::EV_FIELD_W-1:0]    rsp_init_events,
   output logic [elpf_pkg::EV_FIELD_W-1:0]    rsp_loop_events,
   output logic [elpf_pkg::DELAY_W-1:0]       rsp_loop_ms,
   output logic [elpf_pkg::DELAY_W-1:0]       rsp_kept_ms,
   output logic                               rsp_overflow
);

   elpf_pkg::dp_cmd_type cmd;
   elpf_pkg::dp_sts_type sts;

   elpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_last  (req_last),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   elpf_dp #(
      .MAX_EVENTS (MAX_EVENTS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_addr            (csr_addr),
      .csr_wdata           (csr_wdata),
      .req_register_number (req_register_number),
      .req_write_value     (req_write_value),
      .req_delay_after     (req_delay_after),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_found           (rsp_found),
      .rsp_init_events     (rsp_init_events),
      .rsp_loop_events     (rsp_loop_events),
      .rsp_loop_ms         (rsp_loop_ms),
      .rsp_kept_ms         (rsp_kept_ms),
      .rsp_overflow        (rsp_overflow)
   );

endmodule
`default_nettype wire

// File: sim/elpf_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// elpf_result_checker
// Watches the event, result and register ports of the loop period finder,
// keeps its own copy of the event store and the settings, works out the
// loop report for every stream closed by a last event and compares each
// result transaction field by field with the oldest report still waiting.
// ----------------------------------------------------------------------------
module elpf_result_checker #(
   parameter int MAX_EVENTS = elpf_pkg::MAX_EVENTS_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_wr_en,
   input  wire  [elpf_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire  [elpf_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire                             start,
   input  wire                             busy,
   input  wire  [elpf_pkg::REG_NUM_W-1:0]  req_register_number,
   input  wire  [elpf_pkg::VALUE_W-1:0]    req_write_value,
   input  wire  [elpf_pkg::DELAY_W-1:0]    req_delay_after,
   input  wire                             req_last,
   input  wire                             rsp_valid,
   input  wire                             rsp_found,
   input  wire  [elpf_pkg::EV_FIELD_W-1:0] rsp_init_events,
   input  wire  [elpf_pkg::EV_FIELD_W-1:0] rsp_loop_events,
   input  wire  [elpf_pkg::DELAY_W-1:0]    rsp_loop_ms,
   input  wire  [elpf_pkg::DELAY_W-1:0]    rsp_kept_ms,
   input  wire                             rsp_overflow,
   output int                              error_count,
   output int                              open_results
);

   typedef struct packed {
      logic                            found;
      logic [elpf_pkg::EV_FIELD_W-1:0] init_events;
      logic [elpf_pkg::EV_FIELD_W-1:0] loop_events;
      logic [elpf_pkg::DELAY_W-1:0]    loop_ms;
      logic [elpf_pkg::DELAY_W-1:0]    kept_ms;
      logic                            overflow;
   } loop_report_type;

   logic [elpf_pkg::REG_NUM_W-1:0]  ev_reg [MAX_EVENTS];
   logic [elpf_pkg::VALUE_W-1:0]    ev_val [MAX_EVENTS];
   logic [elpf_pkg::DELAY_W-1:0]    ev_dly [MAX_EVENTS];
   int                              stored_count;
   logic                            dropped;
   logic [elpf_pkg::EV_FIELD_W-1:0] cfg_min_events;
   logic [elpf_pkg::DELAY_W-1:0]    cfg_min_ms;
   logic [elpf_pkg::REPEAT_W-1:0]   cfg_min_repeat;
   loop_report_type                 expected_reports [$];
   loop_report_type                 head_report;

   // shortest accepted period over the stored events
   function automatic loop_report_type find_loop();
      int              n;
      int              p;
      int              rep;
      int              s;
      int              i;
      int              keep_n;
      bit              hit;
      logic [31:0]     sum;
      logic [31:0]     kept;
      loop_report_type r;
      n   = stored_count;
      p   = (cfg_min_events == 0) ? 1 : int'(cfg_min_events);
      rep = (cfg_min_repeat == 0) ? 1 : int'(cfg_min_repeat);
      hit = 1'b0;
      r   = '0;
      while (!hit && p * rep <= n) begin
         s = 0;
         for (i = n - p; i > 0 && s == 0; i--) begin
            if (ev_reg[i-1] != ev_reg[i-1+p] || ev_val[i-1] != ev_val[i-1+p] ||
                ev_dly[i-1] != ev_dly[i-1+p]) begin
               s = i;
            end
         end
         if (n - s >= rep * p) begin
            sum = '0;
            for (i = s; i < s + p; i++) sum += ev_dly[i];
            if (sum >= cfg_min_ms) begin
               hit           = 1'b1;
               r.found       = 1'b1;
               r.init_events = s[elpf_pkg::EV_FIELD_W-1:0];
               r.loop_events = p[elpf_pkg::EV_FIELD_W-1:0];
               r.loop_ms     = sum;
            end
         end
         if (!hit) p++;
      end
      if (!hit) r.loop_events = n[elpf_pkg::EV_FIELD_W-1:0];
      keep_n = int'(r.init_events) + int'(r.loop_events);
      if (keep_n > n) keep_n = n;
      kept = '0;
      for (i = 0; i + 1 < keep_n; i++) kept += ev_dly[i];
      r.kept_ms  = kept;
      r.overflow = dropped;
      return r;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h",
                  $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stored_count   = 0;
         dropped        = 1'b0;
         cfg_min_events = elpf_pkg::MIN_PERIOD_EVENTS_RST;
         cfg_min_ms     = elpf_pkg::MIN_PERIOD_MS_RST;
         cfg_min_repeat = elpf_pkg::MIN_REPEAT_RST;
         error_count    = 0;
         expected_reports.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_reports.size() == 0) begin
               note_mismatch("unsolicited result transaction", 32'd0, 32'd1);
            end else begin
               head_report = expected_reports.pop_front();
               if (rsp_found !== head_report.found)
                  note_mismatch("found", 32'(head_report.found), 32'(rsp_found));
               if (rsp_init_events !== head_report.init_events)
                  note_mismatch("init_events", 32'(head_report.init_events),
                                32'(rsp_init_events));
               if (rsp_loop_events !== head_report.loop_events)
                  note_mismatch("loop_events", 32'(head_report.loop_events),
                                32'(rsp_loop_events));
               if (rsp_loop_ms !== head_report.loop_ms)
                  note_mismatch("loop_ms", head_report.loop_ms, rsp_loop_ms);
               if (rsp_kept_ms !== head_report.kept_ms)
                  note_mismatch("kept_ms", head_report.kept_ms, rsp_kept_ms);
               if (rsp_overflow !== head_report.overflow)
                  note_mismatch("overflow", 32'(head_report.overflow), 32'(rsp_overflow));
            end
         end
         if (csr_wr_en) begin
            case (csr_addr)
               elpf_pkg::CSR_MIN_PERIOD_EVENTS:
                  cfg_min_events = csr_wdata[elpf_pkg::EV_FIELD_W-1:0];
               elpf_pkg::CSR_MIN_PERIOD_MS:
                  cfg_min_ms     = csr_wdata[elpf_pkg::DELAY_W-1:0];
               elpf_pkg::CSR_MIN_REPEAT:
                  cfg_min_repeat = csr_wdata[elpf_pkg::REPEAT_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (stored_count < MAX_EVENTS) begin
               ev_reg[stored_count] = req_register_number;
               ev_val[stored_count] = req_write_value;
               ev_dly[stored_count] = req_delay_after;
               stored_count++;
            end else begin
               dropped = 1'b1;
            end
            if (req_last) begin
               expected_reports.push_back(find_loop());
               stored_count = 0;
               dropped      = 1'b0;
            end
         end
      end
      open_results = expected_reports.size();
   end

endmodule

// File: sim/tb_event_stream_loop_period_finder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_event_stream_loop_period_finder_top
// Drives event streams into the loop period finder: a few directed streams
// at the field and register extremes, then random phases of mostly periodic
// streams under changing settings.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_event_stream_loop_period_finder_top;

   typedef struct packed {
      logic [elpf_pkg::REG_NUM_W-1:0] regnum;
      logic [elpf_pkg::VALUE_W-1:0]   value;
      logic [elpf_pkg::DELAY_W-1:0]   delay;
   } timed_write_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_wr_en;
   logic [elpf_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [elpf_pkg::CSR_DATA_W-1:0] csr_wdata;
   logic                            start;
   logic                            busy;
   logic [elpf_pkg::REG_NUM_W-1:0]  req_register_number;
   logic [elpf_pkg::VALUE_W-1:0]    req_write_value;
   logic [elpf_pkg::DELAY_W-1:0]    req_delay_after;
   logic                            req_last;
   logic                            rsp_valid;
   logic                            rsp_found;
   logic [elpf_pkg::EV_FIELD_W-1:0] rsp_init_events;
   logic [elpf_pkg::EV_FIELD_W-1:0] rsp_loop_events;
   logic [elpf_pkg::DELAY_W-1:0]    rsp_loop_ms;
   logic [elpf_pkg::DELAY_W-1:0]    rsp_kept_ms;
   logic                            rsp_overflow;
   int                              error_count;
   int                              open_results;

   timed_write_type stream_q [$];
   int              idle_pct;

   event_stream_loop_period_finder_top #(.MAX_EVENTS(elpf_pkg::MAX_EVENTS_DEF)) u_top (.*);

   elpf_result_checker #(.MAX_EVENTS(elpf_pkg::MAX_EVENTS_DEF)) u_checker (.*);

   always #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic logic [31:0] pick_delay();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 400);
      if (r < 90) return $urandom();
      if (r < 95) return 32'd0;
      return 32'hffff_ffff;
   endfunction

   function automatic timed_write_type rand_write(input bit narrow);
      timed_write_type w;
      if (narrow) begin
         w.regnum = $urandom_range(0, 1) ? 9'd256 : 9'd1;
         w.value  = $urandom_range(0, 1) ? 8'hff : 8'h00;
         w.delay  = $urandom_range(0, 2) * 10;
      end else begin
         w.regnum = elpf_pkg::REG_NUM_W'($urandom_range(0, 511));
         w.value  = elpf_pkg::VALUE_W'($urandom_range(0, 255));
         w.delay  = pick_delay();
      end
      return w;
   endfunction

   // prefix, then copies of one period, then part of one more copy
   task automatic build_periodic(input int pre_len, input int per_len, input int copies,
                                 input int partial, input bit narrow, input bit corrupt);
      timed_write_type pat [$];
      int              idx;
      stream_q.delete();
      repeat (pre_len) stream_q.push_back(rand_write(narrow));
      repeat (per_len) pat.push_back(rand_write(narrow));
      repeat (copies) begin
         foreach (pat[j]) stream_q.push_back(pat[j]);
      end
      for (int j = 0; j < partial; j++) stream_q.push_back(pat[j]);
      if (corrupt) begin
         idx = $urandom_range(0, stream_q.size() - 1);
         if ($urandom_range(0, 1))
            stream_q[idx].delay ^= 32'h1 << $urandom_range(0, 31);
         else
            stream_q[idx].value ^= 8'h1 << $urandom_range(0, 7);
      end
   endtask

   task automatic build_noise(input int len, input bit narrow);
      stream_q.delete();
      repeat (len) stream_q.push_back(rand_write(narrow));
   endtask

   // entered and left just after a falling edge; start stays high on return
   task automatic push_write(input timed_write_type w, input bit is_last);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start               <= 1'b1;
      req_register_number <= w.regnum;
      req_write_value     <= w.value;
      req_delay_after     <= w.delay;
      req_last            <= is_last;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic send_stream();
      foreach (stream_q[k]) push_write(stream_q[k], k == stream_q.size() - 1);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (open_results != 0 || busy) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input logic [elpf_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [elpf_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [31:0] min_events, input logic [31:0] min_ms,
                             input logic [31:0] min_rep);
      write_csr(elpf_pkg::CSR_MIN_PERIOD_EVENTS, min_events);
      write_csr(elpf_pkg::CSR_MIN_PERIOD_MS, min_ms);
      write_csr(elpf_pkg::CSR_MIN_REPEAT, min_rep);
   endtask

   initial begin
      int          random_sent;
      int          streams_sent;
      int          pick;
      logic [31:0] cfg_events;
      logic [31:0] cfg_ms;
      logic [31:0] cfg_rep;
      int          per_len;

      clock               = 1'b0;
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_addr            <= '0;
      csr_wdata           <= '0;
      start               <= 1'b0;
      req_register_number <= '0;
      req_write_value     <= '0;
      req_delay_after     <= '0;
      req_last            <= 1'b0;
      idle_pct            = 22;
      random_sent         = 0;
      streams_sent        = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: a single event is too short for any period
      stream_q.delete();
      stream_q.push_back({9'd511, 8'd255, 32'hffff_ffff});
      send_stream();

      // zero minimum length and zero repeat count both act as one
      settle();
      set_config(32'd0, 32'd0, 32'd0);
      stream_q.delete();
      stream_q.push_back({9'd0, 8'd0, 32'd0});
      send_stream();
      stream_q.delete();
      stream_q.push_back({9'd0, 8'd0, 32'd5});
      repeat (3) stream_q.push_back({9'd511, 8'd255, 32'hffff_ffff});
      send_stream();

      // period sum exactly at the largest threshold, repeat count 8
      settle();
      set_config(32'd2, 32'hffff_ffff, 32'd8);
      stream_q.delete();
      repeat (8) begin
         stream_q.push_back({9'd256, 8'd1, 32'hffff_fffe});
         stream_q.push_back({9'd255, 8'd254, 32'd1});
      end
      send_stream();

      while (random_sent < 700 || streams_sent < 30) begin
         settle();
         pick = $urandom_range(0, 99);
         if (pick < 10)      cfg_events = 0;
         else if (pick < 65) cfg_events = $urandom_range(1, 6);
         else if (pick < 85) cfg_events = $urandom_range(7, 20);
         else if (pick < 92) cfg_events = 8191;
         else                cfg_events = 4096;
         pick = $urandom_range(0, 99);
         if (pick < 10)      cfg_rep = 0;
         else if (pick < 80) cfg_rep = $urandom_range(1, 4);
         else if (pick < 90) cfg_rep = 8;
         else                cfg_rep = 15;
         pick = $urandom_range(0, 99);
         if (pick < 45)      cfg_ms = 0;
         else if (pick < 80) cfg_ms = $urandom_range(0, 800);
         else if (pick < 90) cfg_ms = 32'hffff_ffff;
         else                cfg_ms = $urandom();
         // upper bits beyond each register's width must be ignored
         set_config(($urandom() << elpf_pkg::EV_FIELD_W) | cfg_events, cfg_ms,
                    ($urandom() << elpf_pkg::REPEAT_W) | cfg_rep);
         repeat ($urandom_range(1, 4)) begin
            idle_pct = (random_sent >= 250 && random_sent < 400) ? 0 : 22;
            pick     = $urandom_range(0, 99);
            per_len  = $urandom_range(1, 6);
            if (pick < 80)
               build_periodic($urandom_range(0, 6), per_len, $urandom_range(1, 5),
                              $urandom_range(0, per_len - 1), $urandom_range(0, 99) < 35,
                              $urandom_range(0, 99) < 15);
            else if (pick < 95)
               build_noise($urandom_range(1, 30), $urandom_range(0, 1) == 1);
            else
               build_periodic($urandom_range(0, 40), $urandom_range(5, 30),
                              $urandom_range(3, 8), 0, 1'b0, $urandom_range(0, 1) == 1);
            send_stream();
            random_sent += stream_q.size();
            streams_sent++;
         end
      end

      settle();
      repeat (40) @(negedge clock);
      if (error_count == 0 && open_results == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
